// ===== rtl/core/sqvg_pkg.sv =====
// Package for the sprite quad vertex generator: widths, corner codes, shared
// structs and the quarter-wave sine table, which is built at elaboration.
// No dependencies.
`default_nettype none

package sqvg_pkg;

    localparam int COORD_BITS      = 24;
    localparam int SIZE_BITS       = 24;
    localparam int ANGLE_BITS      = 16;
    localparam int ANGLE_POS_BITS  = 14;
    localparam int TEX_BITS        = 16;
    localparam int LAYER_BITS      = 8;

    localparam int SINE_DEPTH      = 256;
    localparam int SINE_IDX_BITS   = $clog2(SINE_DEPTH + 1);
    localparam int SINE_ENTRY_BITS = 15;
    localparam int TRIG_BITS       = 16;

    // Product of a Q16.8 size and a Q1.14 trig value, plus a guard bit.
    localparam int PROD_BITS       = SIZE_BITS + TRIG_BITS + 1;
    localparam int PROD_SHIFT      = 15;
    localparam int POS_BITS        = COORD_BITS + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [(SINE_DEPTH + 1) * SINE_ENTRY_BITS - 1:0] t_rom_bits;

    // Emission order of the four vertices of a quad.
    typedef enum logic [1:0] {
        CORNER_LL = 2'd0,
        CORNER_LR = 2'd1,
        CORNER_UR = 2'd2,
        CORNER_UL = 2'd3
    } t_corner;

    typedef struct packed {
        logic signed [TRIG_BITS-1:0] sin_v;
        logic signed [TRIG_BITS-1:0] cos_v;
    } t_sincos;

    // Per-sprite products, shared by all four corners.
    typedef struct packed {
        logic signed [PROD_BITS-1:0] p_wc;
        logic signed [PROD_BITS-1:0] p_hs;
        logic signed [PROD_BITS-1:0] p_ws;
        logic signed [PROD_BITS-1:0] p_hc;
    } t_prod;

    // Entry k is 16384*sin(pi/2*k/DEPTH), from a Q30 Taylor series with each
    // term truncated, then rounded half up to Q1.14 and capped at one.
    function automatic t_rom_bits f_build_sine_rom();
        t_rom_bits          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        rom = '0;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd32768) >>> 16;
            if (r > 64'sd16384) begin
                r = 64'sd16384;
            end
            rom[k * SINE_ENTRY_BITS +: SINE_ENTRY_BITS] = r[SINE_ENTRY_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_rom_bits SINE_ROM = f_build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/core/sprite_quad_vertex_generator.sv =====
// Top level of the sprite quad vertex generator: stream ports, camera
// registers, three-stage pipeline. Depends on sqvg_pkg, sqvg_sincos and
// sqvg_corner_calc.
//
//   Channel   Dir   Per transfer
//   s_axis    in    one sprite (position, angle, size, texture box, layer)
//   m_axis    out   one vertex (position, texture u/v, layer), four per sprite
//   APB       in    camera_x at 0x0, camera_y at 0x4
//
// A sprite transfer loads stage 1, which also latches sine and cosine from the
// table. Stage 2 holds the four size-by-trig products and the translated
// position; it feeds the output register one vertex per cycle while m_axis
// does not stall. The first vertex of a sprite is offered on m_axis once it
// has been loaded into stage 1, then stage 2, then the output register.
// Stall on m_axis holds every stage; a new sprite is taken while earlier ones
// are still in flight. Synchronous reset empties the pipeline and clears the
// camera registers.
`default_nettype none

module sprite_quad_vertex_generator
    import sqvg_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [23:0] pos_x, [47:24] pos_y, [63:48] angle, [87:64] width,
    // [111:88] height, [127:112] u_left, [143:128] u_right,
    // [159:144] v_low, [175:160] v_high, [183:176] layer
    input  wire logic [183:0] s_axis_tdata,
    // [0] on_ui
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [23:0] vert_x, [47:24] vert_y, [63:48] tex_u, [79:64] tex_v,
    // [87:80] tex_layer
    output logic [87:0]       m_axis_tdata,
    // [1:0] corner
    output logic [1:0]        m_axis_tuser,
    // last_corner
    output logic              m_axis_tlast,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic {
        REG_CAMERA_X = 1'b0,
        REG_CAMERA_Y = 1'b1
    } t_reg_idx;

    // ------------------------------------------------------------------
    // Camera registers
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_camera_x;
    logic signed [COORD_BITS-1:0] r_camera_y;
    t_reg_idx                     reg_idx;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_x <= '0;
            r_camera_y <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_CAMERA_X: r_camera_x <= pwdata[COORD_BITS-1:0];
                REG_CAMERA_Y: r_camera_y <= pwdata[COORD_BITS-1:0];
                default:      r_camera_x <= r_camera_x;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CAMERA_X: prdata = 32'(r_camera_x);
            REG_CAMERA_Y: prdata = 32'(r_camera_y);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake between stages
    // ------------------------------------------------------------------
    logic    r_s1_valid;
    logic    r_s2_valid;
    logic    r_out_valid;
    t_corner r_corner;

    logic    out_load;
    logic    s2_done;
    logic    s2_load;
    logic    s1_load;

    assign out_load      = r_s2_valid && (!r_out_valid || m_axis_tready);
    assign s2_done       = out_load && (r_corner == CORNER_UL);
    assign s2_load       = r_s1_valid && (!r_s2_valid || s2_done);
    assign s_axis_tready = !r_s1_valid || s2_load;
    assign s1_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_corner    <= CORNER_LL;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end

            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end

            // The counter wraps from the last corner back to the first.
            if (s2_load) begin
                r_corner <= CORNER_LL;
            end else if (out_load) begin
                r_corner <= t_corner'(r_corner + 2'd1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sprite fields and table lookup
    // ------------------------------------------------------------------
    t_sincos                      in_sincos;
    t_sincos                      r_s1_sincos;
    logic signed [COORD_BITS-1:0] r_s1_pos_x;
    logic signed [COORD_BITS-1:0] r_s1_pos_y;
    logic [SIZE_BITS-1:0]         r_s1_width;
    logic [SIZE_BITS-1:0]         r_s1_height;
    logic [TEX_BITS-1:0]          r_s1_u_left;
    logic [TEX_BITS-1:0]          r_s1_u_right;
    logic [TEX_BITS-1:0]          r_s1_v_low;
    logic [TEX_BITS-1:0]          r_s1_v_high;
    logic [LAYER_BITS-1:0]        r_s1_layer;
    logic                         r_s1_on_ui;

    sqvg_sincos u_sincos (
        .i_angle  (s_axis_tdata[63:48]),
        .o_sincos (in_sincos)
    );

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_sincos  <= in_sincos;
            r_s1_pos_x   <= s_axis_tdata[23:0];
            r_s1_pos_y   <= s_axis_tdata[47:24];
            r_s1_width   <= s_axis_tdata[87:64];
            r_s1_height  <= s_axis_tdata[111:88];
            r_s1_u_left  <= s_axis_tdata[127:112];
            r_s1_u_right <= s_axis_tdata[143:128];
            r_s1_v_low   <= s_axis_tdata[159:144];
            r_s1_v_high  <= s_axis_tdata[175:160];
            r_s1_layer   <= s_axis_tdata[183:176];
            r_s1_on_ui   <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: four products and translated position, held through the four corners and any stall cycles
    // ------------------------------------------------------------------
    t_prod                        n_s2_prod;
    logic signed [POS_BITS-1:0]   n_s2_pos_x;
    logic signed [POS_BITS-1:0]   n_s2_pos_y;
    logic signed [PROD_BITS-1:0]  w_ext;
    logic signed [PROD_BITS-1:0]  h_ext;
    logic signed [PROD_BITS-1:0]  sin_ext;
    logic signed [PROD_BITS-1:0]  cos_ext;

    t_prod                        r_s2_prod;
    logic signed [POS_BITS-1:0]   r_s2_pos_x;
    logic signed [POS_BITS-1:0]   r_s2_pos_y;
    logic [TEX_BITS-1:0]          r_s2_u_left;
    logic [TEX_BITS-1:0]          r_s2_u_right;
    logic [TEX_BITS-1:0]          r_s2_v_low;
    logic [TEX_BITS-1:0]          r_s2_v_high;
    logic [LAYER_BITS-1:0]        r_s2_layer;

    assign w_ext   = PROD_BITS'(signed'({1'b0, r_s1_width}));
    assign h_ext   = PROD_BITS'(signed'({1'b0, r_s1_height}));
    assign sin_ext = PROD_BITS'(r_s1_sincos.sin_v);
    assign cos_ext = PROD_BITS'(r_s1_sincos.cos_v);

    assign n_s2_prod.p_wc = w_ext * cos_ext;
    assign n_s2_prod.p_hs = h_ext * sin_ext;
    assign n_s2_prod.p_ws = w_ext * sin_ext;
    assign n_s2_prod.p_hc = h_ext * cos_ext;

    // Interface sprites are placed relative to the camera.
    assign n_s2_pos_x = POS_BITS'(r_s1_pos_x)
                      + (r_s1_on_ui ? POS_BITS'(r_camera_x) : '0);
    assign n_s2_pos_y = POS_BITS'(r_s1_pos_y)
                      + (r_s1_on_ui ? POS_BITS'(r_camera_y) : '0);

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_prod    <= n_s2_prod;
            r_s2_pos_x   <= n_s2_pos_x;
            r_s2_pos_y   <= n_s2_pos_y;
            r_s2_u_left  <= r_s1_u_left;
            r_s2_u_right <= r_s1_u_right;
            r_s2_v_low   <= r_s1_v_low;
            r_s2_v_high  <= r_s1_v_high;
            r_s2_layer   <= r_s1_layer;
        end
    end

    // ------------------------------------------------------------------
    // Output register: one vertex per transfer
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] n_vert_x;
    logic [COORD_BITS-1:0] n_vert_y;
    logic [TEX_BITS-1:0]   n_tex_u;
    logic [TEX_BITS-1:0]   n_tex_v;

    logic [COORD_BITS-1:0] r_vert_x;
    logic [COORD_BITS-1:0] r_vert_y;
    logic [TEX_BITS-1:0]   r_tex_u;
    logic [TEX_BITS-1:0]   r_tex_v;
    logic [LAYER_BITS-1:0] r_tex_layer;
    t_corner               r_out_corner;

    sqvg_corner_calc u_corner_calc (
        .i_prod   (r_s2_prod),
        .i_pos_x  (r_s2_pos_x),
        .i_pos_y  (r_s2_pos_y),
        .i_corner (r_corner),
        .o_vert_x (n_vert_x),
        .o_vert_y (n_vert_y)
    );

    // Left texture edge on the left corners, low edge on the lower corners.
    assign n_tex_u = ((r_corner == CORNER_LL) || (r_corner == CORNER_UL))
                   ? r_s2_u_left : r_s2_u_right;
    assign n_tex_v = ((r_corner == CORNER_LL) || (r_corner == CORNER_LR))
                   ? r_s2_v_low : r_s2_v_high;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_vert_x     <= n_vert_x;
            r_vert_y     <= n_vert_y;
            r_tex_u      <= n_tex_u;
            r_tex_v      <= n_tex_v;
            r_tex_layer  <= r_s2_layer;
            r_out_corner <= r_corner;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_tex_layer, r_tex_v, r_tex_u, r_vert_y, r_vert_x};
    assign m_axis_tuser  = r_out_corner;
    assign m_axis_tlast  = (r_out_corner == CORNER_UL);

`ifndef SYNTHESIS
    // An empty stage 2 always starts the next sprite at the first corner.
    a_corner_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_valid |-> (r_corner == CORNER_LL))
        else $error("corner counter left the first corner with stage 2 empty");

    // A vertex that is offered but not taken stays on the bus unchanged.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("vertex changed or dropped while the receiver stalled");

    // A sprite in stage 1 is never dropped before it moves on.
    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_load) |=> r_s1_valid)
        else $error("stage 1 sprite lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sqvg_sincos.sv =====
// Sine and cosine of a binary angle from the quarter-wave table.
// Depends on sqvg_pkg.
`default_nettype none

module sqvg_sincos
    import sqvg_pkg::*;
(
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output t_sincos                    o_sincos
);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    localparam int SCALED_BITS = ANGLE_POS_BITS + SINE_IDX_BITS;

    t_quadrant                          quad;
    logic [SCALED_BITS-1:0]             scaled;
    logic [SINE_IDX_BITS-1:0]           idx_a;
    logic [SINE_IDX_BITS-1:0]           idx_b;
    logic signed [TRIG_BITS-1:0]        ta;
    logic signed [TRIG_BITS-1:0]        tb;

    assign quad   = t_quadrant'(i_angle[ANGLE_BITS-1 -: 2]);
    assign scaled = SCALED_BITS'(i_angle[ANGLE_POS_BITS-1:0])
                  * SCALED_BITS'(SINE_DEPTH);
    assign idx_a  = scaled[ANGLE_POS_BITS +: SINE_IDX_BITS];
    assign idx_b  = SINE_IDX_BITS'(SINE_DEPTH) - idx_a;

    assign ta = signed'({1'b0, SINE_ROM[idx_a * SINE_ENTRY_BITS +: SINE_ENTRY_BITS]});
    assign tb = signed'({1'b0, SINE_ROM[idx_b * SINE_ENTRY_BITS +: SINE_ENTRY_BITS]});

    always_comb begin
        unique case (quad)
            QUAD_0: begin
                o_sincos.sin_v = ta;
                o_sincos.cos_v = tb;
            end
            QUAD_1: begin
                o_sincos.sin_v = tb;
                o_sincos.cos_v = -ta;
            end
            QUAD_2: begin
                o_sincos.sin_v = -ta;
                o_sincos.cos_v = -tb;
            end
            default: begin
                o_sincos.sin_v = -tb;
                o_sincos.cos_v = ta;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sqvg_corner_calc.sv =====
// Position of one quad corner from the per-sprite products: sign, floor,
// translate and saturate. Depends on sqvg_pkg.
`default_nettype none

module sqvg_corner_calc
    import sqvg_pkg::*;
(
    input  wire t_prod                     i_prod,
    input  wire logic signed [POS_BITS-1:0] i_pos_x,
    input  wire logic signed [POS_BITS-1:0] i_pos_y,
    input  wire t_corner                   i_corner,
    output logic [COORD_BITS-1:0]          o_vert_x,
    output logic [COORD_BITS-1:0]          o_vert_y
);

    localparam int TERM_BITS = PROD_BITS - PROD_SHIFT;
    localparam int SUM_BITS  = TERM_BITS + 2;

    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

    logic                        neg_x;
    logic                        neg_y;
    logic signed [PROD_BITS-1:0] s_wc;
    logic signed [PROD_BITS-1:0] s_hs;
    logic signed [PROD_BITS-1:0] s_ws;
    logic signed [PROD_BITS-1:0] s_hc;
    logic signed [TERM_BITS-1:0] f_wc;
    logic signed [TERM_BITS-1:0] f_hs;
    logic signed [TERM_BITS-1:0] f_ws;
    logic signed [TERM_BITS-1:0] f_hc;
    logic signed [SUM_BITS-1:0]  sum_x;
    logic signed [SUM_BITS-1:0]  sum_y;

    // The left corners use -width and the lower corners use -height.
    assign neg_x = (i_corner == CORNER_LL) || (i_corner == CORNER_UL);
    assign neg_y = (i_corner == CORNER_LL) || (i_corner == CORNER_LR);

    assign s_wc = neg_x ? -i_prod.p_wc : i_prod.p_wc;
    assign s_ws = neg_x ? -i_prod.p_ws : i_prod.p_ws;
    assign s_hs = neg_y ? -i_prod.p_hs : i_prod.p_hs;
    assign s_hc = neg_y ? -i_prod.p_hc : i_prod.p_hc;

    // Dropping the low bits of a two's complement value rounds toward minus
    // infinity, which is the truncation the products call for.
    assign f_wc = s_wc[PROD_BITS-1:PROD_SHIFT];
    assign f_hs = s_hs[PROD_BITS-1:PROD_SHIFT];
    assign f_ws = s_ws[PROD_BITS-1:PROD_SHIFT];
    assign f_hc = s_hc[PROD_BITS-1:PROD_SHIFT];

    assign sum_x = SUM_BITS'(f_wc) - SUM_BITS'(f_hs) + SUM_BITS'(i_pos_x);
    assign sum_y = SUM_BITS'(f_ws) + SUM_BITS'(f_hc) + SUM_BITS'(i_pos_y);

    always_comb begin
        priority if (sum_x > SAT_HI) begin
            o_vert_x = SAT_HI[COORD_BITS-1:0];
        end else if (sum_x < SAT_LO) begin
            o_vert_x = SAT_LO[COORD_BITS-1:0];
        end else begin
            o_vert_x = sum_x[COORD_BITS-1:0];
        end
    end

    always_comb begin
        priority if (sum_y > SAT_HI) begin
            o_vert_y = SAT_HI[COORD_BITS-1:0];
        end else if (sum_y < SAT_LO) begin
            o_vert_y = SAT_LO[COORD_BITS-1:0];
        end else begin
            o_vert_y = sum_y[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== verif/sprite_quad_vertex_generator_tb.sv =====
// Self-checking testbench for sprite_quad_vertex_generator: sprites go in on the
// stream input, vertices are checked against a quad predictor kept here.
// Depends on sqvg_pkg for the corner codes and on the RTL of the block.
`timescale 1ns / 100ps

module sprite_quad_vertex_generator_tb;
    import sqvg_pkg::*;

    // Byte addresses of the camera registers on the APB port.
    localparam logic [2:0] CAM_X_ADDR = 3'h0;
    localparam logic [2:0] CAM_Y_ADDR = 3'h4;

    // Quarter-wave table used by the predictor, built here from the series.
    localparam int                TABLE_DEPTH = 256;
    localparam longint unsigned   HALF_PI_Q30 = 64'd1686629713;
    localparam int                TRIG_ONE    = 16384;

    // Clock edges waited after the last owed vertex, so that the pipeline is empty.
    localparam int DRAIN_CYCLES = 8;
    // Long receiver hold-off that backs the pipeline up into the input.
    localparam int HOLD_CYCLES  = 80;
    // Cycles without any transfer on any port before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;

    // Sprite fields, pos_x in the lowest bits so the struct maps onto tdata.
    typedef struct packed {
        logic [7:0]         layer;
        logic [15:0]        v_high;
        logic [15:0]        v_low;
        logic [15:0]        u_right;
        logic [15:0]        u_left;
        logic [23:0]        height;
        logic [23:0]        width;
        logic [15:0]        angle;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_x;
    } sprite_t;

    typedef struct packed {
        t_corner            corner;
        logic               last_corner;
        logic [7:0]         tex_layer;
        logic [15:0]        tex_v;
        logic [15:0]        tex_u;
        logic signed [23:0] vert_y;
        logic signed [23:0] vert_x;
    } vertex_t;

    // One row of the directed table. Rows marked pinned carry the vertex
    // position typed in by hand; all four corners must land there.
    typedef struct {
        sprite_t            sp;
        bit                 on_ui;
        bit                 pinned;
        logic signed [23:0] pin_x;
        logic signed [23:0] pin_y;
    } sprite_row_t;

    logic          i_clk;
    logic          i_rst_n;

    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // [23:0] pos_x, [47:24] pos_y, [63:48] angle, [87:64] width,
    // [111:88] height, [127:112] u_left, [143:128] u_right,
    // [159:144] v_low, [175:160] v_high, [183:176] layer
    logic [183:0]  s_axis_tdata;
    // [0] on_ui
    logic          s_axis_tuser;

    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // [23:0] vert_x, [47:24] vert_y, [63:48] tex_u, [79:64] tex_v,
    // [87:80] tex_layer
    logic [87:0]   m_axis_tdata;
    // [1:0] corner
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    sprite_quad_vertex_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: the sine table and a shadow of the camera registers.
    int                 sine_tab [0:TABLE_DEPTH];
    logic signed [23:0] cam_x = '0;
    logic signed [23:0] cam_y = '0;

    // Vertices still owed by the block, oldest first.
    vertex_t            vertex_q [$];
    sprite_row_t        directed_rows [$];

    int  error_count     = 0;
    int  sprites_sent    = 0;
    int  vertices_seen   = 0;
    int  camera_writes   = 0;
    int  stall_cycles    = 0;
    bit  src_idle_en     = 1'b1;
    bit  sink_idle_en    = 1'b1;
    bit  hold_req        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sin(pi/2 * k / DEPTH) in Q1.14: Q30 Taylor series through x^17 with every
    // term truncated, then rounded half up and capped at one.
    function automatic void build_sine_table();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        for (int k = 0; k <= TABLE_DEPTH; k++) begin
            ang    = HALF_PI_Q30 * longint'(k) / longint'(TABLE_DEPTH);
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n <= 8; n++) begin
                term = term * ang_sq / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            rounded = (acc + 32768) >>> 16;
            if (rounded > TRIG_ONE) begin
                rounded = TRIG_ONE;
            end
            sine_tab[k] = int'(rounded);
        end
    endfunction

    function automatic logic signed [23:0] clamp_coord(input longint v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Works out one vertex of a sprite. The half of width and height is folded
    // into the shift by 15, and each product is floored on its own.
    function automatic vertex_t corner_vertex(input sprite_t sp, input bit on_ui,
                                              input int k);
        vertex_t v;
        longint  px;
        longint  py;
        longint  dx;
        longint  dy;
        longint  s;
        longint  c;
        longint  near_val;
        longint  far_val;
        int      idx;
        px = longint'(sp.pos_x);
        py = longint'(sp.pos_y);
        if (on_ui) begin
            px = px + longint'(cam_x);
            py = py + longint'(cam_y);
        end
        idx      = (int'(sp.angle[13:0]) * TABLE_DEPTH) >> 14;
        near_val = sine_tab[idx];
        far_val  = sine_tab[TABLE_DEPTH - idx];
        case (sp.angle[15:14])
            2'd0: begin s = near_val;  c = far_val;   end
            2'd1: begin s = far_val;   c = -near_val; end
            2'd2: begin s = -near_val; c = -far_val;  end
            default: begin s = -far_val; c = near_val; end
        endcase
        v.corner      = t_corner'(k);
        v.last_corner = (v.corner == CORNER_UL);
        dx = longint'(sp.width);
        dy = longint'(sp.height);
        if (v.corner == CORNER_LL || v.corner == CORNER_UL) begin
            dx = -dx;
        end
        if (v.corner == CORNER_LL || v.corner == CORNER_LR) begin
            dy = -dy;
        end
        v.vert_x    = clamp_coord(((dx * c) >>> 15) - ((dy * s) >>> 15) + px);
        v.vert_y    = clamp_coord(((dx * s) >>> 15) + ((dy * c) >>> 15) + py);
        v.tex_u     = (v.corner == CORNER_LL || v.corner == CORNER_UL) ?
                      sp.u_left : sp.u_right;
        v.tex_v     = (v.corner == CORNER_LL || v.corner == CORNER_LR) ?
                      sp.v_low : sp.v_high;
        v.tex_layer = sp.layer;
        return v;
    endfunction

    task automatic add_row(input logic [23:0] pos_x, input logic [23:0] pos_y,
                           input logic [15:0] angle, input logic [23:0] width,
                           input logic [23:0] height, input logic [15:0] u_left,
                           input logic [15:0] u_right, input logic [15:0] v_low,
                           input logic [15:0] v_high, input logic [7:0] layer,
                           input bit on_ui, input bit pinned,
                           input logic [23:0] pin_x, input logic [23:0] pin_y);
        sprite_row_t row;
        row.sp     = {layer, v_high, v_low, u_right, u_left, height, width, angle,
                      pos_y, pos_x};
        row.on_ui  = on_ui;
        row.pinned = pinned;
        row.pin_x  = pin_x;
        row.pin_y  = pin_y;
        directed_rows.push_back(row);
    endtask

    // Position fields lean toward the small range where rotation is visible,
    // with some full-range values and the two extremes mixed in.
    function automatic logic [23:0] random_coord();
        case ($urandom_range(0, 7))
            0: return 24'($urandom());
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom_range(0, 131071) - 65536);
        endcase
    endfunction

    function automatic logic [23:0] random_size();
        case ($urandom_range(0, 7))
            0: return 24'($urandom());
            1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic sprite_t random_sprite();
        sprite_t sp;
        sp.pos_x   = random_coord();
        sp.pos_y   = random_coord();
        sp.width   = random_size();
        sp.height  = random_size();
        // Now and then sit right on a quadrant boundary, where the table
        // index wraps from one end to the other.
        if ($urandom_range(0, 7) == 0) begin
            sp.angle = {2'($urandom()), 14'h0000} + 16'($urandom_range(0, 2)) - 16'd1;
        end else begin
            sp.angle = 16'($urandom());
        end
        sp.u_left  = 16'($urandom());
        sp.u_right = 16'($urandom());
        sp.v_low   = 16'($urandom());
        sp.v_high  = 16'($urandom());
        sp.layer   = 8'($urandom());
        return sp;
    endfunction

    function automatic int pick_gap();
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // Offers one sprite after an optional idle gap. The four expected vertices
    // are queued as soon as the transfer completes; none of them can leave the
    // block at that same edge.
    task automatic send_sprite(input sprite_t sp, input bit on_ui, input int gap,
                               input bit pinned, input logic [23:0] pin_x,
                               input logic [23:0] pin_y);
        vertex_t v;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sp;
        s_axis_tuser  <= on_ui;
        do @(posedge i_clk); while (!s_axis_tready);
        for (int k = 0; k < 4; k++) begin
            v = corner_vertex(sp, on_ui, k);
            if (pinned) begin
                v.vert_x = pin_x;
                v.vert_y = pin_y;
            end
            vertex_q.push_back(v);
        end
        sprites_sent++;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sprite(random_sprite(), 1'($urandom()), pick_gap(), 1'b0, '0, '0);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every owed vertex has come out, then lets the pipeline empty.
    task automatic drain();
        while (vertex_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen. An idle cycle follows so that back-to-back
    // writes never reassign the bus signals in the same step.
    task automatic write_camera(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            CAM_X_ADDR: cam_x = value[23:0];
            CAM_Y_ADDR: cam_y = value[23:0];
            default: ;
        endcase
        camera_writes++;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [23:0] expv,
                               input logic [23:0] actv);
        if (expv !== actv) begin
            $display("%0t: vertex %0d %s mismatch: expected %0h, actual %0h",
                     $time, vertices_seen, name, expv, actv);
            error_count++;
        end
    endtask

    // Result checker and activity counter for the watchdog. Both stream
    // handshakes are sampled here at the edge where they complete.
    always @(posedge i_clk) begin
        vertex_t exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vertex_q.size() == 0) begin
                $display("%0t: vertex with nothing expected: expected none, actual %0h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                exp_v = vertex_q.pop_front();
                check_field("vert_x", exp_v.vert_x, m_axis_tdata[23:0]);
                check_field("vert_y", exp_v.vert_y, m_axis_tdata[47:24]);
                check_field("tex_u", exp_v.tex_u, m_axis_tdata[63:48]);
                check_field("tex_v", exp_v.tex_v, m_axis_tdata[79:64]);
                check_field("tex_layer", exp_v.tex_layer, m_axis_tdata[87:80]);
                check_field("corner", exp_v.corner, m_axis_tuser);
                check_field("last_corner", exp_v.last_corner, m_axis_tlast);
            end
            vertices_seen++;
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (psel && penable && pready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    // Receiver: short random stalls, one long hold-off on request, and none
    // at all once idling is switched off for the last part of the run.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: no transfer for %0d cycles, %0d vertices still owed",
                 $time, STALL_LIMIT, vertex_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        build_sine_table();

        // Directed rows. Zero-size sprites collapse onto their centre, so their
        // position is typed in; with the camera still at reset an interface
        // sprite must land there too. The rest go through the predictor.
        add_row(24'h000000, 24'h000000, 16'h0000, 24'h000000, 24'h000000,
                16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 0, 1, 24'h000000, 24'h000000);
        add_row(24'h7FFFFF, 24'h800000, 16'hFFFF, 24'h000000, 24'h000000,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 1, 24'h7FFFFF, 24'h800000);
        add_row(24'h00ABCD, 24'hFF1234, 16'h4000, 24'h000000, 24'h000000,
                16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'h5A, 1, 1, 24'h00ABCD, 24'hFF1234);
        // A 1.0 by 2.0 sprite through the quadrant boundaries and some angles
        // in between.
        add_row(24'h001000, 24'h002000, 16'h0000, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 0, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'h4000, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 1, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'h8000, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 0, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'hC000, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 1, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'h2000, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 0, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'h3FFF, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 1, 0, '0, '0);
        add_row(24'h001000, 24'h002000, 16'hFFFF, 24'h000100, 24'h000200,
                16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hA5, 0, 0, '0, '0);
        // Largest sizes against the edges of the coordinate range, so both
        // ends of the saturation are hit.
        add_row(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 24'hFFFFFF, 24'hFFFFFF,
                16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 8'h01, 0, 0, '0, '0);
        add_row(24'h800000, 24'h800000, 16'h8000, 24'hFFFFFF, 24'hFFFFFF,
                16'hFFFE, 16'h0001, 16'h7FFF, 16'h8000, 8'hFE, 1, 0, '0, '0);
        add_row(24'h000000, 24'h000000, 16'h2000, 24'hFFFFFF, 24'hFFFFFF,
                16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'h80, 0, 0, '0, '0);
        add_row(24'h400000, 24'hC00000, 16'h6000, 24'hFFFFFF, 24'h000000,
                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h7F, 0, 0, '0, '0);
        add_row(24'hC00000, 24'h400000, 16'hA000, 24'h000000, 24'hFFFFFF,
                16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 8'h3C, 1, 0, '0, '0);
        // Tiny sizes where the floored products go to minus one.
        add_row(24'hFFFFFF, 24'hFFFFFF, 16'hE000, 24'h000001, 24'h000001,
                16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00, 0, 0, '0, '0);
        add_row(24'h000000, 24'h000000, 16'h0001, 24'h000003, 24'h000003,
                16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF, 0, 0, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_sprite(directed_rows[i].sp, directed_rows[i].on_ui, pick_gap(),
                        directed_rows[i].pinned, directed_rows[i].pin_x,
                        directed_rows[i].pin_y);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // Camera at opposite extremes; interface sprites near the range ends
        // then saturate one way in x and the other in y.
        write_camera(CAM_X_ADDR, 32'h007FFFFF);
        write_camera(CAM_Y_ADDR, 32'h00800000);
        run_random(70);
        drain();

        // Extremes swapped, with junk above bit 23 that the block must drop.
        write_camera(CAM_X_ADDR, 32'hFF800000);
        write_camera(CAM_Y_ADDR, 32'h7F7FFFFF);
        run_random(70);
        drain();

        // Receiver holds off for a long stretch while the sender keeps
        // offering back to back, so the pipeline fills and input stalls.
        write_camera(CAM_X_ADDR, $urandom());
        write_camera(CAM_Y_ADDR, $urandom());
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        run_random(30);
        src_idle_en = 1'b1;
        drain();

        write_camera(CAM_X_ADDR, $urandom());
        write_camera(CAM_Y_ADDR, $urandom());
        run_random(90);
        drain();

        // Last stretch at full rate on both sides.
        write_camera(CAM_X_ADDR, 32'($urandom_range(0, 131071)) - 32'd65536);
        write_camera(CAM_Y_ADDR, 32'($urandom_range(0, 131071)) - 32'd65536);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random(100);
        drain();

        if (vertex_q.size() != 0) begin
            $display("%0t: %0d vertices never arrived", $time, vertex_q.size());
            error_count++;
        end
        $display("Ran %0d sprites through %0d camera settings, %0d vertices compared.",
                 sprites_sent, camera_writes / 2 + 1, vertices_seen);
        $display("Mismatches and protocol errors: %0d.", error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
